// File: rtl/lfu_cache_policy_unit_macros.svh
// ----------------------------------------------------------------------------
// lfu cache policy unit assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_POLICY_UNIT_MACROS_SVH
`define LFU_CACHE_POLICY_UNIT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define LFU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lfu_cache_policy_unit: invariant violated");

// consequent must hold in the same cycle as the antecedent
`define LFU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu_cache_policy_unit: implication violated");

`endif

// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu cache policy unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int DATA_W     = 32;
    localparam int CAP_W      = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_TOUCH,
        ST_TOUCH_WAIT,
        ST_COMMIT,
        ST_RESP
    } lfu_state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic touch_rd;
        logic decide;
        logic commit;
    } lfu_cmd_t;

    typedef struct packed {
        logic last_addr;
        logic act;
        logic need_touch;
    } lfu_sts_t;

endpackage

// File: rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// request sequencer: scan, decide, recency sweep, commit, respond
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  lfu_sts_t sts,
    output lfu_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    lfu_state_t state_reg;
    lfu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.last_addr)
                begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!sts.act)
                begin
                    state_next = ST_RESP;
                end
                else if (sts.need_touch)
                begin
                    state_next = ST_TOUCH;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_TOUCH:
            begin
                if (sts.last_addr)
                begin
                    state_next = ST_TOUCH_WAIT;
                end
            end
            ST_TOUCH_WAIT:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_TOUCH:
            begin
                cmd.touch_rd = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// entry store, scan trackers, replacement decision and recency update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lfu_cache_policy_unit_macros.svh"

module lfu_dp
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfu_cmd_t                 cmd,
    output lfu_sts_t                 sts,
    input  logic [CAP_W-1:0]         capacity,
    input  logic                     req_mode,
    input  logic [DATA_W-1:0]        req_key,
    input  logic [DATA_W-1:0]        req_value,
    output logic                     hit,
    output logic signed [DATA_W-1:0] data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // entry store
    logic [DATA_W-1:0]     mem_key  [ENTRIES];
    logic [DATA_W-1:0]     mem_val  [ENTRIES];
    logic [COUNT_BITS-1:0] mem_cnt  [ENTRIES];
    logic [IDX_W-1:0]      mem_rank [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;
    logic [FILL_W-1:0]  fill_reg;

    // request
    logic              req_mode_reg;
    logic [DATA_W-1:0] req_key_reg;
    logic [DATA_W-1:0] req_val_reg;

    // read port
    logic [IDX_W-1:0]      addr_reg;
    logic                  rd_en;
    logic                  rd_vld_reg;
    logic                  rd_touch_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [DATA_W-1:0]     rd_key_reg;
    logic [DATA_W-1:0]     rd_val_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [IDX_W-1:0]      rd_rank_reg;
    logic                  rd_entry_valid;

    // scan trackers
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic [DATA_W-1:0]     found_val_reg;
    logic [COUNT_BITS-1:0] found_cnt_reg;
    logic [IDX_W-1:0]      found_rank_reg;
    logic                  free_ok_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  vict_ok_reg;
    logic [IDX_W-1:0]      vict_idx_reg;
    logic [COUNT_BITS-1:0] vict_cnt_reg;
    logic [IDX_W-1:0]      vict_rank_reg;

    logic scan_ret;
    logic take_found;
    logic take_vict;
    logic take_free;

    // decision
    logic [CMP_W-1:0]      cap_wide;
    logic [CMP_W-1:0]      cap_eff;
    logic                  dec_act;
    logic                  dec_fill_inc;
    logic [IDX_W-1:0]      dec_slot;
    logic [IDX_W-1:0]      dec_old_rank;
    logic [DATA_W-1:0]     dec_val;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic [DATA_W-1:0]     dec_data;

    logic                  fill_inc_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [IDX_W-1:0]      old_rank_reg;
    logic [DATA_W-1:0]     wr_key_reg;
    logic [DATA_W-1:0]     wr_val_reg;
    logic [COUNT_BITS-1:0] wr_cnt_reg;
    logic                  hit_reg;
    logic [DATA_W-1:0]     data_reg;

    logic tw_en;

    assign rd_en          = cmd.scan_rd | cmd.touch_rd;
    assign rd_entry_valid = valid_reg[rd_idx_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_mode_reg <= req_mode;
            req_key_reg  <= req_key;
            req_val_reg  <= req_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            rd_touch_reg <= 1'b0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.load || cmd.decide)
            begin
                addr_reg <= '0;
            end
            else if (rd_en)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            rd_vld_reg   <= rd_en;
            rd_touch_reg <= cmd.touch_rd;
            rd_idx_reg   <= addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg  <= mem_key[addr_reg];
            rd_val_reg  <= mem_val[addr_reg];
            rd_cnt_reg  <= mem_cnt[addr_reg];
            rd_rank_reg <= mem_rank[addr_reg];
        end
    end

    // scan: first key match, first free slot, lowest count then oldest
    assign scan_ret   = rd_vld_reg && !rd_touch_reg;
    assign take_found = scan_ret && rd_entry_valid && !found_reg && (rd_key_reg == req_key_reg);
    assign take_vict  = scan_ret && rd_entry_valid &&
                        (!vict_ok_reg || (rd_cnt_reg < vict_cnt_reg) ||
                         ((rd_cnt_reg == vict_cnt_reg) && (rd_rank_reg > vict_rank_reg)));
    assign take_free  = scan_ret && !rd_entry_valid && !free_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            vict_ok_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            vict_ok_reg <= 1'b0;
        end
        else
        begin
            if (take_found)
            begin
                found_reg <= 1'b1;
            end
            if (take_free)
            begin
                free_ok_reg <= 1'b1;
            end
            if (take_vict)
            begin
                vict_ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_found)
        begin
            found_idx_reg  <= rd_idx_reg;
            found_val_reg  <= rd_val_reg;
            found_cnt_reg  <= rd_cnt_reg;
            found_rank_reg <= rd_rank_reg;
        end
        if (take_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (take_vict)
        begin
            vict_idx_reg  <= rd_idx_reg;
            vict_cnt_reg  <= rd_cnt_reg;
            vict_rank_reg <= rd_rank_reg;
        end
    end

    // capacity above the store size is clamped
    assign cap_wide = CMP_W'(capacity);
    assign cap_eff  = (cap_wide > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_wide;

    always_comb
    begin
        dec_act      = 1'b0;
        dec_fill_inc = 1'b0;
        dec_slot     = found_idx_reg;
        dec_old_rank = found_rank_reg;
        dec_val      = req_val_reg;
        dec_cnt      = COUNT_BITS'(1);
        dec_data     = '0;
        if (found_reg)
        begin
            dec_act = 1'b1;
            if (req_mode_reg == MODE_GET)
            begin
                dec_val  = found_val_reg;
                dec_data = found_val_reg;
            end
            if (found_cnt_reg == COUNT_MAX)
            begin
                dec_cnt = found_cnt_reg;
            end
            else
            begin
                dec_cnt = found_cnt_reg + COUNT_BITS'(1);
            end
        end
        else if (req_mode_reg == MODE_GET)
        begin
            dec_data = '1;
        end
        else if (capacity != '0)
        begin
            if ((CMP_W'(fill_reg) < cap_eff) && free_ok_reg)
            begin
                dec_act      = 1'b1;
                dec_fill_inc = 1'b1;
                dec_slot     = free_idx_reg;
                dec_old_rank = IDX_W'(fill_reg);
            end
            else if (vict_ok_reg)
            begin
                dec_act      = 1'b1;
                dec_slot     = vict_idx_reg;
                dec_old_rank = vict_rank_reg;
            end
        end
    end

    assign sts.last_addr  = (addr_reg == LAST_IDX);
    assign sts.act        = dec_act;
    assign sts.need_touch = (dec_old_rank != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_inc_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            fill_inc_reg <= dec_fill_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            slot_reg     <= dec_slot;
            old_rank_reg <= dec_old_rank;
            wr_key_reg   <= req_key_reg;
            wr_val_reg   <= dec_val;
            wr_cnt_reg   <= dec_cnt;
            hit_reg      <= found_reg;
            data_reg     <= dec_data;
        end
    end

    // entries newer than the touched one age by one
    assign tw_en = rd_vld_reg && rd_touch_reg && rd_entry_valid &&
                   (rd_idx_reg != slot_reg) && (rd_rank_reg < old_rank_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem_key[slot_reg]  <= wr_key_reg;
            mem_val[slot_reg]  <= wr_val_reg;
            mem_cnt[slot_reg]  <= wr_cnt_reg;
            mem_rank[slot_reg] <= '0;
        end
        else if (tw_en)
        begin
            mem_rank[rd_idx_reg] <= rd_rank_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg[slot_reg] <= 1'b1;
            if (fill_inc_reg)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    assign hit  = hit_reg;
    assign data = $signed(data_reg);

    `LFU_ASSERT_ALWAYS(a_fill_matches_valid, clk, rst_n, $countones(valid_reg) == fill_reg)
    `LFU_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= ENTRIES)
    `LFU_ASSERT_IMPLY(a_insert_into_free, clk, rst_n, cmd.commit && fill_inc_reg, !valid_reg[slot_reg])
    `LFU_ASSERT_IMPLY(a_commit_port_free, clk, rst_n, cmd.commit, !rd_vld_reg)

endmodule

// File: rtl/lfu_cache_policy_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_policy_unit
// key-value cache with least-frequently-used replacement, lru tie break
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. Every request
// scans the entry store one entry per cycle through its single read port;
// a get miss or a put with nothing to store then goes straight to the
// response, a hit or insert whose slot already holds the most recent rank
// (the first insert into an empty store among them) goes on to commit,
// others age the recency ranks in a second pass first. The result
// comes out as a single-cycle done pulse with hit and data; the receiver
// cannot stall it, so it must take the result in that cycle. Reset leaves
// every entry invalid at once; no clearing pass is needed. Write capacity
// over the apb port only while busy is low.
`timescale 1ns / 1ps

module lfu_cache_policy_unit
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic signed [DATA_W-1:0]     key,
    input  logic signed [DATA_W-1:0]     value,
    output logic                         done,
    output logic                         hit,
    output logic signed [DATA_W-1:0]     data
);

    logic [CAP_W-1:0]     capacity_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    lfu_cmd_t             cmd;
    lfu_sts_t             sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr && (reg_idx == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_CAPACITY:
            begin
                prdata = {{(APB_DATA_W - CAP_W){1'b0}}, capacity_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    lfu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lfu_dp #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .capacity  (capacity_reg),
        .req_mode  (mode),
        .req_key   ($unsigned(key)),
        .req_value ($unsigned(value)),
        .hit       (hit),
        .data      (data)
    );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the lfu cache policy unit against a cycle-free model of the cache:
// directed corner requests, random get/put traffic over a small key pool
// across several capacity settings, and a hot-key run with no idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import lfu_pkg::*;

    localparam int NUM_LINES = ENTRIES_DEF;
    localparam int SLOWEST_REQ = 2 * NUM_LINES + 5;
    localparam int POOL_SIZE = 20;
    localparam int HOT_GETS = 12;
    localparam logic [COUNT_BITS_DEF-1:0] USE_MAX = '1;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } cache_req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [DATA_W-1:0] data;
    } cache_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic mode = MODE_GET;
    logic signed [DATA_W-1:0] key = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic done;
    logic hit;
    logic signed [DATA_W-1:0] data;

    lfu_cache_policy_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .mode    (mode),
        .key     (key),
        .value   (value),
        .done    (done),
        .hit     (hit),
        .data    (data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cache model state
    bit                        line_valid [NUM_LINES];
    logic signed [DATA_W-1:0]  line_key   [NUM_LINES];
    logic signed [DATA_W-1:0]  line_data  [NUM_LINES];
    logic [COUNT_BITS_DEF-1:0] line_uses  [NUM_LINES];
    int                        line_rank  [NUM_LINES];
    int                        lines_filled = 0;
    logic [CAP_W-1:0]          cap_shadow = CAP_RESET;

    cache_req_t    pending_requests [$];
    cache_result_t expected_results [$];

    int  mismatch_cnt = 0;
    int  results_checked = 0;
    int  reqs_accepted = 0;
    int  hit_total = 0;
    int  evict_total = 0;
    int  cfg_writes = 0;
    int  idle_left = 0;
    bit  idle_en = 1'b1;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_cnt++;
    endtask

    function automatic void make_most_recent(input int s, input int old_rank);
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (i != s && line_valid[i] && line_rank[i] < old_rank)
                line_rank[i]++;
        end
        line_rank[s] = 0;
    endfunction

    function automatic cache_result_t cache_access(input cache_req_t req);
        cache_result_t res;
        int found;
        int slot;
        int old_rank;
        int eff_cap;
        found = -1;
        slot = -1;
        eff_cap = (cap_shadow > NUM_LINES) ? NUM_LINES : int'(cap_shadow);
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (found < 0 && line_valid[i] && line_key[i] == req.key)
                found = i;
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (req.mode == MODE_GET)
                res.data = line_data[found];
            else
            begin
                line_data[found] = req.value;
                res.data = '0;
            end
            if (line_uses[found] != USE_MAX)
                line_uses[found]++;
            make_most_recent(found, line_rank[found]);
            hit_total++;
            return res;
        end
        res.hit = 1'b0;
        res.data = (req.mode == MODE_GET) ? -1 : 0;
        if (req.mode == MODE_GET || eff_cap == 0)
            return res;
        if (lines_filled < eff_cap)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                if (slot < 0 && !line_valid[i])
                    slot = i;
            end
        end
        if (slot >= 0)
        begin
            line_valid[slot] = 1'b1;
            lines_filled++;
            old_rank = lines_filled - 1;
        end
        else
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                if (line_valid[i] && (slot < 0 || line_uses[i] < line_uses[slot] ||
                    (line_uses[i] == line_uses[slot] && line_rank[i] > line_rank[slot])))
                    slot = i;
            end
            if (slot < 0)
                return res;
            old_rank = line_rank[slot];
            evict_total++;
        end
        line_key[slot] = req.key;
        line_data[slot] = req.value;
        line_uses[slot] = COUNT_BITS_DEF'(1);
        make_most_recent(slot, old_rank);
        return res;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        cache_req_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(cache_access(cache_req_t'{mode, key, value}));
                reqs_accepted++;
            end
            if (!(start && busy))
            begin
                if (idle_left == 0 && idle_en && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 13);
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    nxt = pending_requests.pop_front();
                    start <= 1'b1;
                    mode  <= nxt.mode;
                    key   <= nxt.key;
                    value <= nxt.value;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = expected_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit got %0b want %0b",
                        results_checked, hit, want.hit));
                if (data !== want.data)
                    report_mismatch($sformatf("result %0d data got %h want %h",
                        results_checked, data, want.data));
                results_checked++;
            end
        end
    end

    task automatic queue_req(input logic m, input logic [31:0] k, input logic [31:0] v);
        pending_requests.push_back(cache_req_t'{m, k, v});
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] wdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CAPACITY)
            cap_shadow = wdata[CAP_W-1:0];
        cfg_writes++;
    endtask

    task automatic check_capacity_reg();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CAP_W-1:0] !== cap_shadow)
            report_mismatch($sformatf("capacity reads %0d want %0d",
                prdata[CAP_W-1:0], cap_shadow));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        apb_write(REG_CAPACITY, ($urandom & 32'hFFFF_FFE0) | 32'(cap));
        check_capacity_reg();
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] key_pool [POOL_SIZE];
        logic [CAP_W-1:0] cap_plan [8];
        logic [31:0] sat_key;
        logic [31:0] k;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        cap_plan = '{5'd1, 5'd16, 5'd0, 5'd3, 5'd31, 5'd8, 5'd2, 5'd0};
        cap_plan[7] = CAP_W'($urandom_range(4, 30));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_capacity_reg();

        // directed: extremes, update, miss on empty and on absent key
        queue_req(MODE_GET, 32'h0000_0000, $urandom);
        queue_req(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(MODE_PUT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        queue_req(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_req(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_req(MODE_GET, 32'h0000_0000, $urandom);
        queue_req(MODE_GET, 32'h1234_5678, $urandom);
        queue_req(MODE_GET, 32'hFFFF_FFFF, $urandom);

        // write to an unmapped register must not touch capacity
        wait_idle();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        check_capacity_reg();

        // capacity lowered below the fill: evictions reuse slots
        set_capacity(5'd2);
        queue_req(MODE_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_req(MODE_GET, 32'h7FFF_FFFF, $urandom);
        queue_req(MODE_GET, 32'h8000_0000, $urandom);
        queue_req(MODE_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        queue_req(MODE_GET, 32'h5555_5555, $urandom);

        // capacity zero: new keys are dropped, stored ones still hit
        set_capacity(5'd0);
        queue_req(MODE_PUT, 32'h1111_1111, 32'h2222_2222);
        queue_req(MODE_GET, 32'h1111_1111, $urandom);
        queue_req(MODE_PUT, 32'h8000_0000, 32'h3333_3333);
        queue_req(MODE_GET, 32'hFFFF_FFFF, $urandom);

        // capacity above the entry count clamps
        set_capacity(5'd31);
        queue_req(MODE_PUT, 32'h0000_0001, 32'h0000_0001);
        queue_req(MODE_PUT, 32'h0000_0002, 32'h0000_0002);
        queue_req(MODE_PUT, 32'h0000_0003, 32'h0000_0003);
        queue_req(MODE_GET, 32'h0000_0002, $urandom);

        // random traffic over a key pool, one capacity per phase
        for (int ph = 0; ph < 8; ph++)
        begin
            set_capacity(cap_plan[ph]);
            for (int j = 0; j < 3; j++)
                key_pool[$urandom_range(5, POOL_SIZE - 1)] = $urandom;
            for (int n = 0; n < 70; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    k = $urandom;
                queue_req(1'($urandom_range(0, 1)), k, $urandom);
            end
        end

        // repeated gets on one hot key, no idling from here on
        set_capacity(5'd16);
        idle_en = 1'b0;
        sat_key = $urandom;
        queue_req(MODE_PUT, sat_key, 32'hC0DE_0001);
        for (int n = 0; n < HOT_GETS; n++)
            queue_req(MODE_GET, sat_key, $urandom);
        set_capacity(5'd1);
        queue_req(MODE_PUT, ~sat_key, $urandom);
        queue_req(MODE_GET, sat_key, $urandom);
        queue_req(MODE_PUT, sat_key ^ 32'h8000_0001, $urandom);
        queue_req(MODE_GET, sat_key, $urandom);

        wait_idle();
        repeat (SLOWEST_REQ) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at the end");
        $display("checked %0d results of %0d requests: %0d hits, %0d evictions",
            results_checked, reqs_accepted, hit_total, evict_total);
        $display("%0d register writes, hot-key run of %0d back-to-back gets",
            cfg_writes, HOT_GETS);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
